// File: src/ctpl_pkg.sv
package ctpl_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TPS_HIGH_LIMIT = 3'd0,
      CSR_TPS_LOW_LIMIT  = 3'd1,
      CSR_CRANK_TIME_MIN = 3'd2,
      CSR_BATTERY_MIN    = 3'd3,
      CSR_CREEP_STEP     = 3'd4,
      CSR_STABLE_WINDOW  = 3'd5,
      CSR_STABLE_TIME    = 3'd6,
      CSR_IDLE_OFFSET    = 3'd7
   } csr_index_type;

   localparam logic [9:0]  RST_TPS_HIGH_LIMIT = 10'd192;
   localparam logic [9:0]  RST_TPS_LOW_LIMIT  = 10'd40;
   localparam logic [15:0] RST_CRANK_TIME_MIN = 16'd200;
   localparam logic [7:0]  RST_BATTERY_MIN    = 8'd136;
   localparam logic [9:0]  RST_CREEP_STEP     = 10'd12;
   localparam logic [9:0]  RST_STABLE_WINDOW  = 10'd4;
   localparam logic [7:0]  RST_STABLE_TIME    = 8'd120;
   localparam logic [9:0]  RST_IDLE_OFFSET    = 10'd0;

   localparam logic [8:0]  CORR_BIAS  = 9'h080;
   localparam logic [8:0]  CORR_MAX   = 9'h0FF;
   localparam logic [10:0] RAISE_STEP = 11'd4;
   localparam int unsigned FLAG_DONE   = 0;
   localparam int unsigned FLAG_RAISED = 1;

   typedef struct packed {
      logic [9:0]  tps_high_limit;
      logic [9:0]  tps_low_limit;
      logic [15:0] crank_time_min;
      logic [7:0]  battery_min;
      logic [9:0]  creep_step;
      logic [9:0]  stable_window;
      logic [7:0]  stable_time;
      logic [9:0]  idle_offset;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  tps_raw8;
      logic [7:0]  tps_adder;
      logic [9:0]  tps_raw10;
      logic        learn_enable;
      logic        crank_or_stall;
      logic [15:0] since_crank_end;
      logic [7:0]  battery_level;
      logic        racing_mode;
      logic [6:0]  call_phase;
   } item_type;

   typedef struct packed {
      logic [9:0] learned;
      logic [1:0] flags;
      logic [9:0] candidate;
      logic [7:0] count;
   } learn_state_type;

   typedef struct packed {
      logic [7:0]  corrected_tps;
      logic [9:0]  learned_tps;
      logic [10:0] idle_threshold;
      logic [1:0]  learned_flags;
      logic        conditions_ok;
   } result_type;

endpackage

// File: src/ctpl_csr.sv
module ctpl_csr
   import ctpl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TPS_HIGH_LIMIT: cfg_in.tps_high_limit = csr_data[9:0];
            CSR_TPS_LOW_LIMIT:  cfg_in.tps_low_limit  = csr_data[9:0];
            CSR_CRANK_TIME_MIN: cfg_in.crank_time_min = csr_data[15:0];
            CSR_BATTERY_MIN:    cfg_in.battery_min    = csr_data[7:0];
            CSR_CREEP_STEP:     cfg_in.creep_step     = csr_data[9:0];
            CSR_STABLE_WINDOW:  cfg_in.stable_window  = csr_data[9:0];
            CSR_STABLE_TIME:    cfg_in.stable_time    = csr_data[7:0];
            CSR_IDLE_OFFSET:    cfg_in.idle_offset    = csr_data[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tps_high_limit <= RST_TPS_HIGH_LIMIT;
         cfg_ff.tps_low_limit  <= RST_TPS_LOW_LIMIT;
         cfg_ff.crank_time_min <= RST_CRANK_TIME_MIN;
         cfg_ff.battery_min    <= RST_BATTERY_MIN;
         cfg_ff.creep_step     <= RST_CREEP_STEP;
         cfg_ff.stable_window  <= RST_STABLE_WINDOW;
         cfg_ff.stable_time    <= RST_STABLE_TIME;
         cfg_ff.idle_offset    <= RST_IDLE_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/ctpl_step.sv
module ctpl_step
   import ctpl_pkg::*;
(
   input  cfg_type         cfg,
   input  item_type        item,
   input  learn_state_type state_cur,
   output learn_state_type state_nxt,
   output result_type      result
);

   logic [8:0]  sum;
   logic [8:0]  sum_off;
   logic [7:0]  corrected;
   logic [7:0]  count_dec;
   logic [1:0]  flags1;
   logic        ok;
   logic        creep;
   logic [9:0]  creep_base;
   logic [9:0]  learned1;
   logic [10:0] window_top;
   logic        unstable;
   logic [10:0] raised;
   logic [9:0]  learned_new;

   always_comb begin
      sum     = {1'b0, item.tps_adder} + {1'b0, item.tps_raw8};
      sum_off = sum - CORR_BIAS;
      if (sum < CORR_BIAS) begin
         corrected = 8'd0;
      end else if (sum_off > CORR_MAX) begin
         corrected = 8'hFF;
      end else begin
         corrected = sum_off[7:0];
      end
   end

   assign count_dec = (state_cur.count != 8'd0) ? state_cur.count - 8'd1 : 8'd0;

   always_comb begin
      flags1 = state_cur.flags;
      if (item.tps_raw10 > cfg.tps_high_limit) begin
         flags1[FLAG_RAISED] = 1'b0;
      end
   end

   assign ok = !(item.crank_or_stall
                 || (item.since_crank_end <= cfg.crank_time_min)
                 || (item.battery_level <= cfg.battery_min)
                 || (item.tps_raw10 < cfg.tps_low_limit)
                 || (item.tps_raw10 > cfg.tps_high_limit)
                 || item.racing_mode);

   assign creep = ok && !flags1[FLAG_DONE] && (item.call_phase == 7'd0)
                  && (item.tps_raw10 >= state_cur.learned);

   always_comb begin
      creep_base = (state_cur.learned > cfg.creep_step) ?
                   state_cur.learned - cfg.creep_step : 10'd0;
      if (creep) begin
         learned1 = (creep_base >= item.tps_raw10) ? creep_base : item.tps_raw10;
      end else begin
         learned1 = state_cur.learned;
      end
   end

   assign window_top = {1'b0, state_cur.candidate} + {1'b0, cfg.stable_window};
   assign unstable   = !ok || (state_cur.candidate > item.tps_raw10)
                       || ({1'b0, item.tps_raw10} > window_top);
   assign raised     = {1'b0, learned1} + RAISE_STEP;

   always_comb begin
      state_nxt       = state_cur;
      state_nxt.count = count_dec;
      if (item.learn_enable) begin
         state_nxt.flags   = flags1;
         state_nxt.learned = learned1;
         if (unstable) begin
            state_nxt.count     = cfg.stable_time;
            state_nxt.candidate = item.tps_raw10;
         end else if (count_dec == 8'd0) begin
            state_nxt.count = cfg.stable_time;
            if (learned1 >= state_cur.candidate) begin
               state_nxt.flags[FLAG_DONE] = 1'b1;
               state_nxt.learned          = state_cur.candidate;
               state_nxt.candidate        = item.tps_raw10;
            end else if (!flags1[FLAG_RAISED]) begin
               state_nxt.flags = 2'b11;
               state_nxt.learned = (raised > {1'b0, state_cur.candidate}) ?
                                   state_cur.candidate : raised[9:0];
               state_nxt.candidate = item.tps_raw10;
            end
         end
      end
   end

   assign learned_new = state_nxt.learned;

   always_comb begin
      result.corrected_tps  = corrected;
      result.learned_tps    = learned_new;
      result.idle_threshold = {1'b0, learned_new} + {1'b0, cfg.idle_offset};
      result.learned_flags  = state_nxt.flags;
      result.conditions_ok  = item.learn_enable && ok;
   end

endmodule

// File: src/closed_throttle_position_learner.sv
// Closed-throttle position learner.
// Each request transaction carries one 200 Hz step of throttle readings and
// engine conditions, and each produces exactly one response transaction with
// the corrected throttle value, the learned closed position, the idle
// threshold, the learned flags and the learning condition status.
// A request is registered on acceptance and is evaluated from that register;
// when it moves on, the learner state and the response register are updated
// together. One request can be taken in every cycle while req_stall is low;
// the rate is set by the single evaluation stage.
// When the receiver raises rsp_stall, the response holds steady and the input
// register keeps one more request, after which req_stall is raised.
// The configuration registers are written through the csr channel, which is
// always ready; writes take effect in the next cycle and belong to idle times.
// Reset clears the learner state and the pipeline, and loads the register
// defaults.
module closed_throttle_position_learner
   import ctpl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_tps_raw8,
   input  logic [7:0]             req_tps_adder,
   input  logic [9:0]             req_tps_raw10,
   input  logic                   req_learn_enable,
   input  logic                   req_crank_or_stall,
   input  logic [15:0]            req_since_crank_end,
   input  logic [7:0]             req_battery_level,
   input  logic                   req_racing_mode,
   input  logic [6:0]             req_call_phase,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_corrected_tps,
   output logic [9:0]             rsp_learned_tps,
   output logic [10:0]            rsp_idle_threshold,
   output logic [1:0]             rsp_learned_flags,
   output logic                   rsp_conditions_ok,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type         cfg;
   item_type        req_item;
   item_type        s1_item_ff;
   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   learn_state_type state_ff;
   learn_state_type state_in;
   result_type      result_in;
   result_type      result_ff;
   logic            out_free;
   logic            s1_move;
   logic            req_take;

   ctpl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ctpl_step u_step (
      .cfg       (cfg),
      .item      (s1_item_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_comb begin
      req_item.tps_raw8        = req_tps_raw8;
      req_item.tps_adder       = req_tps_adder;
      req_item.tps_raw10       = req_tps_raw10;
      req_item.learn_enable    = req_learn_enable;
      req_item.crank_or_stall  = req_crank_or_stall;
      req_item.since_crank_end = req_since_crank_end;
      req_item.battery_level   = req_battery_level;
      req_item.racing_mode     = req_racing_mode;
      req_item.call_phase      = req_call_phase;
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (s1_move) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_corrected_tps  = result_ff.corrected_tps;
   assign rsp_learned_tps    = result_ff.learned_tps;
   assign rsp_idle_threshold = result_ff.idle_threshold;
   assign rsp_learned_flags  = result_ff.learned_flags;
   assign rsp_conditions_ok  = result_ff.conditions_ok;

endmodule

// File: src/ctpl_checker.sv
module ctpl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_corrected_tps,
   input logic [9:0]  rsp_learned_tps,
   input logic [10:0] rsp_idle_threshold,
   input logic [1:0]  rsp_learned_flags
);

   // A held response transaction stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A held response transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_corrected_tps) && $stable(rsp_learned_tps)
                                 && $stable(rsp_idle_threshold)
                                 && $stable(rsp_learned_flags))
      else $error("response payload changed while stalled");

   // The raised flag is only ever set together with the learned-done flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_learned_flags[1] && !rsp_learned_flags[0]))
      else $error("raised flag without learned flag");

   // Once learned, the done flag never clears again until reset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_learned_flags[0] ##1 rsp_valid |-> rsp_learned_flags[0])
      else $error("learned flag cleared");

   // The idle threshold never wraps below the learned position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_idle_threshold >= {1'b0, rsp_learned_tps})
      else $error("idle threshold below learned position");

endmodule

bind closed_throttle_position_learner ctpl_checker u_ctpl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_corrected_tps  (rsp_corrected_tps),
   .rsp_learned_tps    (rsp_learned_tps),
   .rsp_idle_threshold (rsp_idle_threshold),
   .rsp_learned_flags  (rsp_learned_flags)
);
